@@ src/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
// No dependencies; imported by every module of the block.
package cau_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // Per-item status that travels alongside the magnitudes
    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } flags_t;

endpackage

@@ src/cau_mul.sv @@
// Product stage: four cross products, two squares and the add/subtract sums.
// Depends on cau_pkg.
module cau_mul import cau_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                  clk,
    input  logic                  en,
    input  op_t                   op,
    input  logic signed [W-1:0]   a_re,
    input  logic signed [W-1:0]   a_im,
    input  logic signed [W-1:0]   b_re,
    input  logic signed [W-1:0]   b_im,
    output op_t                   op_reg,
    output logic signed [2*W-1:0] p_rr_reg,
    output logic signed [2*W-1:0] p_ii_reg,
    output logic signed [2*W-1:0] p_ri_reg,
    output logic signed [2*W-1:0] p_ir_reg,
    output logic signed [2*W-1:0] p_bb_reg,
    output logic signed [2*W-1:0] p_cc_reg,
    output logic signed [W:0]     as_re_reg,
    output logic signed [W:0]     as_im_reg
);

    logic signed [W:0] as_re_next;
    logic signed [W:0] as_im_next;

    // Add or subtract part by part, one guard bit
    always_comb
    begin
        if (op == OP_SUB)
        begin
            as_re_next = {a_re[W-1], a_re} - {b_re[W-1], b_re};
            as_im_next = {a_im[W-1], a_im} - {b_im[W-1], b_im};
        end
        else
        begin
            as_re_next = {a_re[W-1], a_re} + {b_re[W-1], b_re};
            as_im_next = {a_im[W-1], a_im} + {b_im[W-1], b_im};
        end
    end

    // Register the products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg    <= op;
            p_rr_reg  <= a_re * b_re;
            p_ii_reg  <= a_im * b_im;
            p_ri_reg  <= a_re * b_im;
            p_ir_reg  <= a_im * b_re;
            p_bb_reg  <= b_re * b_re;
            p_cc_reg  <= b_im * b_im;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
    end

endmodule

@@ src/cau_sum.sv @@
// Sum stage: combine products into exact signed parts and the divisor norm.
// Depends on cau_pkg.
module cau_sum import cau_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                  clk,
    input  logic                  en,
    input  op_t                   op,
    input  logic signed [2*W-1:0] p_rr,
    input  logic signed [2*W-1:0] p_ii,
    input  logic signed [2*W-1:0] p_ri,
    input  logic signed [2*W-1:0] p_ir,
    input  logic signed [2*W-1:0] p_bb,
    input  logic signed [2*W-1:0] p_cc,
    input  logic signed [W:0]     as_re,
    input  logic signed [W:0]     as_im,
    output op_t                   op_reg,
    output logic signed [2*W:0]   s_re_reg,
    output logic signed [2*W:0]   s_im_reg,
    output logic [2*W-1:0]        den_reg
);

    localparam int MW = 2 * W + 1;

    logic signed [MW-1:0] s_re_next;
    logic signed [MW-1:0] s_im_next;
    logic signed [MW-1:0] rr_x, ii_x, ri_x, ir_x;

    assign rr_x = {p_rr[2*W-1], p_rr};
    assign ii_x = {p_ii[2*W-1], p_ii};
    assign ri_x = {p_ri[2*W-1], p_ri};
    assign ir_x = {p_ir[2*W-1], p_ir};

    // Select the part sums by operation
    always_comb
    begin
        unique case (op)
            OP_ADD, OP_SUB:
            begin
                s_re_next = {{(MW-W-1){as_re[W]}}, as_re};
                s_im_next = {{(MW-W-1){as_im[W]}}, as_im};
            end
            OP_MUL:
            begin
                s_re_next = rr_x - ii_x;
                s_im_next = ri_x + ir_x;
            end
            default:
            begin
                s_re_next = rr_x + ii_x;
                s_im_next = ir_x - ri_x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op;
            s_re_reg <= s_re_next;
            s_im_reg <= s_im_next;
            den_reg  <= p_bb[2*W-1:0] + p_cc[2*W-1:0];
        end
    end

endmodule

@@ src/cau_prep.sv @@
// Prepare stage: sign and magnitude, fraction shift, quotient range check.
// Depends on cau_pkg.
module cau_prep import cau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  op_t                  op,
    input  logic signed [2*W:0]  s_re,
    input  logic signed [2*W:0]  s_im,
    input  logic [2*W-1:0]       den,
    output logic [2*W+F:0]       rem_re_reg,
    output logic [2*W+F:0]       rem_im_reg,
    output logic [2*W-1:0]       den_reg,
    output flags_t               flags_reg
);

    localparam int MW = 2 * W + 1;
    localparam int NW = MW + F;
    localparam int CW = NW + W + 1;

    logic [MW-1:0] mag_re, mag_im;
    logic [NW-1:0] mw_re, mw_im;
    logic [NW-1:0] rem_re_next, rem_im_next;
    logic [CW-1:0] den_top;
    flags_t        flags_next;

    assign mag_re = s_re[MW-1] ? (~s_re + 1'b1) : s_re;
    assign mag_im = s_im[MW-1] ? (~s_im + 1'b1) : s_im;
    assign mw_re  = NW'(mag_re);
    assign mw_im  = NW'(mag_im);

    // Divisor shifted past the widest quotient kept
    assign den_top = CW'(den) << (W + 1);

    always_comb
    begin
        flags_next        = '0;
        flags_next.neg_re = s_re[MW-1];
        flags_next.neg_im = s_im[MW-1];
        unique case (op)
            OP_ADD, OP_SUB:
            begin
                rem_re_next = mw_re;
                rem_im_next = mw_im;
            end
            OP_MUL:
            begin
                rem_re_next = mw_re >> F;
                rem_im_next = mw_im >> F;
            end
            default:
            begin
                rem_re_next       = mw_re << F;
                rem_im_next       = mw_im << F;
                flags_next.is_div = 1'b1;
                flags_next.dz     = (den == '0);
                flags_next.big_re = (CW'(mw_re << F) >= den_top);
                flags_next.big_im = (CW'(mw_im << F) >= den_top);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            den_reg    <= den;
            flags_reg  <= flags_next;
        end
    end

endmodule

@@ src/cau_div.sv @@
// One restoring-division step: decides a single quotient bit for both parts.
// Depends on cau_pkg.
module cau_div import cau_pkg::*;
#(
    parameter int W    = 32,
    parameter int F    = 16,
    parameter int STEP = 0
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [2*W+F:0] rem_re,
    input  logic [2*W+F:0] rem_im,
    input  logic [W:0]     q_re,
    input  logic [W:0]     q_im,
    input  logic [2*W-1:0] den,
    input  flags_t         flags,
    output logic [2*W+F:0] rem_re_reg,
    output logic [2*W+F:0] rem_im_reg,
    output logic [W:0]     q_re_reg,
    output logic [W:0]     q_im_reg,
    output logic [2*W-1:0] den_reg,
    output flags_t         flags_reg
);

    localparam int NW = 2 * W + 1 + F;
    localparam int CW = NW + W + 1;
    localparam int QW = W + 1;

    logic [CW-1:0] dsh;
    logic          ge_re, ge_im;

    // Trial subtract of the shifted divisor; pass-through for other ops
    assign dsh   = CW'(den) << STEP;
    assign ge_re = flags.is_div && (CW'(rem_re) >= dsh);
    assign ge_im = flags.is_div && (CW'(rem_im) >= dsh);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= ge_re ? NW'(CW'(rem_re) - dsh) : rem_re;
            rem_im_reg <= ge_im ? NW'(CW'(rem_im) - dsh) : rem_im;
            q_re_reg   <= q_re | (QW'(ge_re) << STEP);
            q_im_reg   <= q_im | (QW'(ge_im) << STEP);
            den_reg    <= den;
            flags_reg  <= flags;
        end
    end

endmodule

@@ src/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit: handshake, stage chain, saturation.
// Depends on cau_pkg, cau_mul, cau_sum, cau_prep and cau_div.
//
//  Channel  Dir  Contents
//  s_*      in   tuser: op; tdata: a_re, a_im, b_re, b_im
//  m_*      out  tuser: overflow, div_zero; tdata: res_re, res_im
//
// The divider chain resolves one quotient bit per stage; one transfer per
// cycle while the output is not stalled.
// Every stage holds a valid bit; a stage takes new data when it is empty or
// its successor moves, so bubbles close up under back-pressure.
// Reset clears only the valid bits.
module complex_arithmetic_unit import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]                            s_tuser,  // op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,  // res_re, res_im
    output logic [1:0]                            m_tuser   // overflow, div_zero
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int MW   = 2 * W + 1;
    localparam int NW   = MW + F;
    localparam int L    = W + 5;
    localparam int OD_W = ((2*W+7)/8)*8;

    logic [L-1:0] v_reg;
    logic [L-1:0] en;

    // Advance a stage when empty or when the next one advances
    assign en[L-1] = ~v_reg[L-1] | m_tready;
    genvar k;
    generate
        for (k = 0; k < L - 1; k++)
        begin : g_en
            assign en[k] = ~v_reg[k] | en[k+1];
        end
    endgenerate

    assign s_tready = en[0];
    assign m_tvalid = v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < L; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Products
    op_t                   op_m;
    logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
    logic signed [W:0]     as_re, as_im;

    cau_mul #(.W(W)) u_mul
    (
        .clk       (clk),
        .en        (en[0]),
        .op        (s_tuser),
        .a_re      (s_tdata[W-1:0]),
        .a_im      (s_tdata[2*W-1:W]),
        .b_re      (s_tdata[3*W-1:2*W]),
        .b_im      (s_tdata[4*W-1:3*W]),
        .op_reg    (op_m),
        .p_rr_reg  (p_rr),
        .p_ii_reg  (p_ii),
        .p_ri_reg  (p_ri),
        .p_ir_reg  (p_ir),
        .p_bb_reg  (p_bb),
        .p_cc_reg  (p_cc),
        .as_re_reg (as_re),
        .as_im_reg (as_im)
    );

    // Sums
    op_t                 op_s;
    logic signed [MW-1:0] s_re, s_im;
    logic [2*W-1:0]      den_s;

    cau_sum #(.W(W)) u_sum
    (
        .clk      (clk),
        .en       (en[1]),
        .op       (op_m),
        .p_rr     (p_rr),
        .p_ii     (p_ii),
        .p_ri     (p_ri),
        .p_ir     (p_ir),
        .p_bb     (p_bb),
        .p_cc     (p_cc),
        .as_re    (as_re),
        .as_im    (as_im),
        .op_reg   (op_s),
        .s_re_reg (s_re),
        .s_im_reg (s_im),
        .den_reg  (den_s)
    );

    // Divider chain, one quotient bit per stage, most significant first
    logic [NW-1:0]  rem_re_c [0:W+1];
    logic [NW-1:0]  rem_im_c [0:W+1];
    logic [W:0]     q_re_c   [0:W+1];
    logic [W:0]     q_im_c   [0:W+1];
    logic [2*W-1:0] den_c    [0:W+1];
    flags_t         flags_c  [0:W+1];

    cau_prep #(.W(W), .F(F)) u_prep
    (
        .clk        (clk),
        .en         (en[2]),
        .op         (op_s),
        .s_re       (s_re),
        .s_im       (s_im),
        .den        (den_s),
        .rem_re_reg (rem_re_c[0]),
        .rem_im_reg (rem_im_c[0]),
        .den_reg    (den_c[0]),
        .flags_reg  (flags_c[0])
    );

    assign q_re_c[0] = '0;
    assign q_im_c[0] = '0;

    generate
        for (k = 0; k <= W; k++)
        begin : g_div
            cau_div #(.W(W), .F(F), .STEP(W - k)) u_div
            (
                .clk        (clk),
                .en         (en[3+k]),
                .rem_re     (rem_re_c[k]),
                .rem_im     (rem_im_c[k]),
                .q_re       (q_re_c[k]),
                .q_im       (q_im_c[k]),
                .den        (den_c[k]),
                .flags      (flags_c[k]),
                .rem_re_reg (rem_re_c[k+1]),
                .rem_im_reg (rem_im_c[k+1]),
                .q_re_reg   (q_re_c[k+1]),
                .q_im_reg   (q_im_c[k+1]),
                .den_reg    (den_c[k+1]),
                .flags_reg  (flags_c[k+1])
            );
        end
    endgenerate

    // Saturate and restore sign
    flags_t        fl;
    logic [NW-1:0] mag_re, mag_im, lim_re, lim_im;
    logic          sat_re, sat_im;
    logic [W-1:0]  val_re, val_im, res_re, res_im;
    logic [NW-1:0] half;

    assign fl     = flags_c[W+1];
    assign half   = NW'(1) << (W - 1);
    assign mag_re = fl.is_div ? NW'(q_re_c[W+1]) : rem_re_c[W+1];
    assign mag_im = fl.is_div ? NW'(q_im_c[W+1]) : rem_im_c[W+1];
    assign lim_re = fl.neg_re ? half : half - 1'b1;
    assign lim_im = fl.neg_im ? half : half - 1'b1;
    assign sat_re = fl.big_re || (mag_re > lim_re);
    assign sat_im = fl.big_im || (mag_im > lim_im);
    assign val_re = sat_re ? lim_re[W-1:0] : mag_re[W-1:0];
    assign val_im = sat_im ? lim_im[W-1:0] : mag_im[W-1:0];
    assign res_re = fl.neg_re ? (~val_re + 1'b1) : val_re;
    assign res_im = fl.neg_im ? (~val_im + 1'b1) : val_im;

    logic [OD_W-1:0] m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    // Output register; zero result on a zero divisor
    always_ff @(posedge clk)
    begin
        if (en[L-1])
        begin
            if (fl.dz)
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b10;
            end
            else
            begin
                m_tdata_reg <= OD_W'({res_im, res_re});
                m_tuser_reg <= {1'b0, sat_re | sat_im};
            end
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // A zero divisor never reports overflow and gives a zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("div_zero result not zero");

    // Overflow leaves at least one part at one of its two limits
    a_ovf_lim: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[W-1:0] == {1'b0, {(W-1){1'b1}}}) ||
            (m_tdata[W-1:0] == {1'b1, {(W-1){1'b0}}}) ||
            (m_tdata[2*W-1:W] == {1'b0, {(W-1){1'b1}}}) ||
            (m_tdata[2*W-1:W] == {1'b1, {(W-1){1'b0}}}))
        else $error("overflow without a saturated part");

    // A free output lets the whole chain advance
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

endmodule
